>>> src/crp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants for the Catmull-Rom path player.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int COORD_W    = 32;   // Q16.16 coordinate
  localparam int MAX_POINTS = 16;   // control point slots
  localparam int FRAC_W     = 17;   // t in Q0.16, one extra bit for t = 1.0

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

  // Command codes of an input transaction
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_PLAY = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  // Configuration register indexes
  localparam logic REG_POINT_COUNT  = 1'b0;
  localparam logic REG_TOTAL_FRAMES = 1'b1;

  // Axis select codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] point_index;
    coord_t     point_x;
    coord_t     point_y;
    coord_t     point_z;
  } req_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   playing;
    logic   finished;
  } rsp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       do_load;
    logic       do_play;
    logic       do_stop;
    logic       rd_stale;
    logic       div_seg;
    logic       seg_latch;
    logic       step;
    logic       div_frac;
    logic       frac_latch;
    logic       rd_pt;
    logic       ev_init;
    logic       ev_step;
    logic       ev_wb;
    logic       out_load;
    logic [1:0] sel;
    logic [1:0] axis;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       playing;
    logic       running;
    logic       stale;
    logic       need_div;
    logic       div_done;
  } ctrl_stat_t;

endpackage

>>> src/crp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per
// cycle. The upper dividend half must be below the divisor.
// ----------------------------------------------------------------------------
module crp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] quotient
);

  logic [15:0] rem;
  logic [15:0] dq;     // dividend bits shift out, quotient bits shift in
  logic [15:0] dvs;    // divisor held for the whole division
  logic [3:0]  cnt;
  logic [16:0] sh;
  logic [16:0] diff;
  logic        ge;

  // one trial subtract
  assign sh   = {rem, dq[15]};
  assign ge   = sh >= {1'b0, dvs};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[31:16];
      dq  <= dividend[15:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[15:0] : sh[15:0];
      dq  <= {dq[14:0], ge};
    end
  end

  assign quotient = dq;

endmodule

>>> src/crp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_datapath
// Point store, playback state, divider, shared Horner multiplier and the
// result register.
// ----------------------------------------------------------------------------
module crp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  crp_pkg::ctrl_cmd_t  cmd,
  output crp_pkg::ctrl_stat_t stat,
  input  crp_pkg::req_t       req,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output crp_pkg::rsp_t       rsp
);
  import crp_pkg::*;

  localparam int H_W = 40;   // Horner accumulator, covers the widest coefficient sum
  localparam int P_W = H_W + FRAC_W;
  localparam logic signed [H_W-1:0] SAT_HI = (H_W'(1) << (COORD_W - 1)) - H_W'(1);
  localparam logic signed [H_W-1:0] SAT_LO = ~SAT_HI;

  req_t          req_q;
  point_t        mem [MAX_POINTS];
  point_t        p0_shadow;
  point_t        pts [4];
  point_t        stale_pt;
  logic          stale_q;
  point_t        last_pos;
  logic          play;
  logic [3:0]    seg_idx;
  logic [15:0]   frame;
  logic [4:0]    pc_reg;
  logic [15:0]   tf_reg;
  logic [15:0]   seg_frames;
  logic [FRAC_W-1:0] frac;
  logic signed [H_W-1:0] h;
  rsp_t          rsp_q;

  logic [4:0]    pc_eff;
  logic [4:0]    last_seg_w;
  logic [3:0]    last_seg;
  logic [4:0]    stale_addr_w;
  logic [3:0]    rd_addr;
  logic          reached;
  logic          div_start;
  logic [31:0]   div_dividend;
  logic [15:0]   div_divisor;
  logic          div_busy;
  logic          div_done;
  logic [15:0]   div_q;

  function automatic coord_t get_axis(point_t p, logic [1:0] ax);
    coord_t v;
    case (ax)
      AXIS_X:  v = p.x;
      AXIS_Y:  v = p.y;
      default: v = p.z;
    endcase
    return v;
  endfunction

  // effective point count, segment count, stale point address
  always_comb begin
    if (pc_reg < 5'd4)                     pc_eff = 5'd4;
    else if (pc_reg > 5'(MAX_POINTS))      pc_eff = 5'(MAX_POINTS);
    else                                   pc_eff = pc_reg;
    last_seg_w   = pc_eff - 5'd3;
    last_seg     = last_seg_w[3:0];
    stale_addr_w = pc_eff - 5'd2;
  end

  assign reached = (seg_frames == 16'd0) || (frame >= seg_frames);

  assign stat.command  = req_q.command;
  assign stat.playing  = play;
  assign stat.running  = frame < tf_reg;
  assign stat.stale    = (seg_idx == 4'd0) || (seg_idx > last_seg);
  assign stat.need_div = !reached;
  assign stat.div_done = div_done;

  // read address: stale point or window point seg-1+k
  assign rd_addr = cmd.rd_stale ? stale_addr_w[3:0]
                                : seg_idx + {2'b00, cmd.sel} - 4'd1;

  // divider operands
  assign div_start    = cmd.div_seg || cmd.div_frac;
  assign div_dividend = cmd.div_seg ? {16'd0, tf_reg} : {frame, 16'd0};
  assign div_divisor  = cmd.div_seg ? {12'd0, last_seg} : seg_frames;

  crp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // point store
  always_ff @(posedge clk) begin
    if (cmd.do_load) begin
      mem[req_q.point_index] <= '{x: req_q.point_x, y: req_q.point_y, z: req_q.point_z};
    end
    if (cmd.rd_pt) begin
      pts[cmd.sel] <= mem[rd_addr];
    end
    if (cmd.rd_stale) begin
      stale_pt <= mem[rd_addr];
    end
  end

  // input capture and copy of slot 0
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.do_load && req_q.point_index == 4'd0) begin
      p0_shadow <= '{x: req_q.point_x, y: req_q.point_y, z: req_q.point_z};
    end
  end

  // coefficients for the selected axis
  logic signed [H_W-1:0] q0, q1, q2, q3;
  logic signed [H_W-1:0] co_a, co_b, co_c, co_d, coef;
  logic signed [P_W-1:0] prod;
  logic signed [P_W-1:0] scaled;
  logic signed [H_W-1:0] half;
  coord_t                sat;

  always_comb begin
    q0   = H_W'(get_axis(pts[0], cmd.axis));
    q1   = H_W'(get_axis(pts[1], cmd.axis));
    q2   = H_W'(get_axis(pts[2], cmd.axis));
    q3   = H_W'(get_axis(pts[3], cmd.axis));
    co_a = q3 - q0 + ((q1 - q2) <<< 1) + (q1 - q2);
    co_b = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    co_c = q2 - q0;
    co_d = q1 <<< 1;
    case (cmd.sel)
      2'd0:    coef = co_b;
      2'd1:    coef = co_c;
      default: coef = co_d;
    endcase
  end

  // Horner step: floor(h * t / 2^16) + coef
  assign prod   = h * $signed({1'b0, frac});
  assign scaled = prod >>> 16;

  // halve and saturate
  always_comb begin
    half = h >>> 1;
    if (half > SAT_HI)      sat = SAT_HI[COORD_W-1:0];
    else if (half < SAT_LO) sat = SAT_LO[COORD_W-1:0];
    else                    sat = half[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_init) begin
      h <= co_a;
    end else if (cmd.ev_step) begin
      h <= scaled[H_W-1:0] + coef;
    end
  end

  // divider results
  always_ff @(posedge clk) begin
    if (cmd.seg_latch) begin
      seg_frames <= div_q;
    end
  end

  // playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      play     <= 1'b0;
      seg_idx  <= 4'd1;
      frame    <= '0;
      last_pos <= '0;
      pc_reg   <= 5'd4;
      tf_reg   <= 16'd60;
      stale_q  <= 1'b0;
      frac     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT:  pc_reg <= cfg_data[4:0];
          default:          tf_reg <= cfg_data;
        endcase
      end
      if (cmd.capture) stale_q <= 1'b0;
      if (cmd.rd_stale) stale_q <= 1'b1;
      if (cmd.do_load) begin
        seg_idx <= 4'd1;
        frame   <= '0;
      end
      if (cmd.do_play) play <= 1'b1;
      if (cmd.do_stop) begin
        play     <= 1'b0;
        last_pos <= p0_shadow;
      end
      if (cmd.seg_latch) frame <= frame + 16'd1;
      // end of segment: advance or hold t at one
      if (cmd.step && reached) begin
        if (seg_idx < last_seg) begin
          seg_idx <= seg_idx + 4'd1;
          frame   <= '0;
          frac    <= '0;
        end else begin
          frac <= ONE_Q16;
        end
      end
      if (cmd.frac_latch) frac <= {1'b0, div_q};
      if (cmd.ev_wb) begin
        case (cmd.axis)
          AXIS_X:  last_pos.x <= sat;
          AXIS_Y:  last_pos.y <= sat;
          default: last_pos.z <= sat;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (stale_q) begin
        rsp_q.pos_x <= stale_pt.x;
        rsp_q.pos_y <= stale_pt.y;
        rsp_q.pos_z <= stale_pt.z;
      end else if (play) begin
        rsp_q.pos_x <= last_pos.x;
        rsp_q.pos_y <= last_pos.y;
        rsp_q.pos_z <= last_pos.z;
      end else begin
        rsp_q.pos_x <= p0_shadow.x;
        rsp_q.pos_y <= p0_shadow.y;
        rsp_q.pos_z <= p0_shadow.z;
      end
      rsp_q.playing  <= play;
      rsp_q.finished <= frame >= tf_reg;
    end
  end

  assign rsp = rsp_q;

  a_seg_nonzero: assert property (@(posedge clk) disable iff (rst) seg_idx != 4'd0)
    else $error("segment index reached zero");
  a_frac_range: assert property (@(posedge clk) disable iff (rst) frac <= ONE_Q16)
    else $error("t above one");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_seg || cmd.div_frac) |-> !div_busy)
    else $error("divider started while busy");

endmodule

>>> src/crp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_ctrl
// Sequencer: decodes each transaction, runs the divisions, the point reads
// and the per-axis Horner steps, and owns the output valid.
// ----------------------------------------------------------------------------
module crp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  crp_pkg::ctrl_stat_t stat,
  output crp_pkg::ctrl_cmd_t  cmd
);
  import crp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_EXEC = 11'b000_0000_0010,
    S_DIVS = 11'b000_0000_0100,
    S_STEP = 11'b000_0000_1000,
    S_DIVT = 11'b000_0001_0000,
    S_RD   = 11'b000_0010_0000,
    S_EVI  = 11'b000_0100_0000,
    S_EVS  = 11'b000_1000_0000,
    S_EVW  = 11'b001_0000_0000,
    S_RES  = 11'b010_0000_0000,
    S_HOLD = 11'b100_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] cnt, cnt_next;
  logic [1:0] ax, ax_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ax_next    = ax;
    cmd        = '0;
    cmd.axis   = ax;
    cmd.sel    = cnt;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = rsp_valid && rsp_stall;
        if (req_valid && !req_stall) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RES;
        unique case (stat.command)
          CMD_LOAD: cmd.do_load = 1'b1;
          CMD_PLAY: cmd.do_play = 1'b1;
          CMD_STOP: cmd.do_stop = 1'b1;
          default: begin
            if (stat.playing && stat.running) begin
              if (stat.stale) begin
                cmd.rd_stale = 1'b1;
              end else begin
                cmd.div_seg = 1'b1;
                state_next  = S_DIVS;
              end
            end
          end
        endcase
      end
      S_DIVS: begin
        if (stat.div_done) begin
          cmd.seg_latch = 1'b1;
          state_next    = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        cnt_next = '0;
        if (stat.need_div) begin
          cmd.div_frac = 1'b1;
          state_next   = S_DIVT;
        end else begin
          state_next = S_RD;
        end
      end
      S_DIVT: begin
        cnt_next = '0;
        if (stat.div_done) begin
          cmd.frac_latch = 1'b1;
          state_next     = S_RD;
        end
      end
      // fetch the four window points
      S_RD: begin
        cmd.rd_pt = 1'b1;
        cnt_next  = cnt + 2'd1;
        if (cnt == 2'd3) begin
          ax_next    = AXIS_X;
          state_next = S_EVI;
        end
      end
      S_EVI: begin
        cmd.ev_init = 1'b1;
        cnt_next    = '0;
        state_next  = S_EVS;
      end
      S_EVS: begin
        cmd.ev_step = 1'b1;
        cnt_next    = cnt + 2'd1;
        if (cnt == 2'd2) state_next = S_EVW;
      end
      S_EVW: begin
        cmd.ev_wb = 1'b1;
        if (ax == AXIS_Z) begin
          state_next = S_RES;
        end else begin
          ax_next    = ax + 2'd1;
          state_next = S_EVI;
        end
      end
      S_RES: begin
        cmd.out_load = 1'b1;
        state_next   = S_HOLD;
      end
      S_HOLD: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ax        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ax    <= ax_next;
      if (cmd.out_load)                 rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> (!rsp_valid || !rsp_stall))
    else $error("transaction accepted while result pending");
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> rsp_valid)
    else $error("result loaded but not valid");
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_RES)
    else $error("output valid raised outside result state");

endmodule

>>> src/catmull_rom_path_player.sv
`timescale 1ns / 1ps
// Load, play, stop, idle and stale ticks skip the divisions and evaluation.
// A playing tick has one or two 16-step divisions (segment length, t), four point-store
// reads, and for each of 3 axes three steps on the shared Horner multiplier.
// Throughput: one transaction at a time; the next is taken once the result is out.
// Reset (synchronous, rst high) clears playback state and presets the config registers;
// the point store is not cleared and holds no valid bits.
// ----------------------------------------------------------------------------
// catmull_rom_path_player
// 3D Catmull-Rom path playback over stored control points, one frame per tick.
// ----------------------------------------------------------------------------
module catmull_rom_path_player (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  crp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output crp_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);
  import crp_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  crp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  crp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp       (rsp)
  );

endmodule
